[hw/rtl/pdc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_pkg: shared constants for the PWM period and duty capture block
// Action codes, field widths, reset values and queue sizing.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // Input item fields
  localparam int unsigned ACTION_W        = 2;
  localparam int unsigned CAPTURE_W       = 16;

  // Configuration register
  localparam int unsigned CLOCK_W         = 27;
  localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = 27'd32000000;

  // Result item fields
  localparam int unsigned FREQ_W          = 27;
  localparam int unsigned DUTY_W          = 7;
  localparam int unsigned DUTY_MAX        = 100;
  localparam int unsigned SCALE_W         = 7;
  localparam logic [SCALE_W-1:0] DUTY_SCALE = 7'd100;

  // Timer counter width default
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Entries between front and back
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_RISE    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FALL    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MEASURE = 2'd2;

  // Divider sequencer
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } pdc_state_e;

endpackage
`default_nettype wire

[hw/rtl/pdc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_if: valid/ready channels of the PWM period and duty capture block
// One interface for input items, one for result items.
// ----------------------------------------------------------------------------
interface pdc_in_if;
  logic                           valid;
  logic                           ready;
  logic [pdc_pkg::ACTION_W-1:0]   action;
  logic [pdc_pkg::CAPTURE_W-1:0]  capture_count;

  modport source (output valid, action, capture_count, input ready);
  modport sink   (input valid, action, capture_count, output ready);
endinterface

interface pdc_out_if;
  logic                         valid;
  logic                         ready;
  logic [pdc_pkg::FREQ_W-1:0]   frequency_hz;
  logic [pdc_pkg::DUTY_W-1:0]   duty_percent;
  logic                         no_period;

  modport source (output valid, frequency_hz, duty_percent, no_period, input ready);
  modport sink   (input valid, frequency_hz, duty_percent, no_period, output ready);
endinterface
`default_nettype wire

[hw/rtl/pdc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_front: capture registers and measure classification
// Takes input transactions, keeps edge counts and the kept period and high
// time, and pushes one measure entry per measure request into the queue.
// ----------------------------------------------------------------------------
module pdc_front #(
  parameter int unsigned COUNT_WIDTH = pdc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  pdc_in_if.sink                 in_i,
  output logic                   push_o,
  output logic [COUNT_WIDTH-1:0] push_period_o,
  output logic [COUNT_WIDTH-1:0] push_high_o,
  input  logic                   full_i
);
  import pdc_pkg::*;

  logic [COUNT_WIDTH-1:0] rise_new_q, rise_new_d;
  logic [COUNT_WIDTH-1:0] rise_prev_q, rise_prev_d;
  logic [COUNT_WIDTH-1:0] fall_new_q, fall_new_d;
  logic [COUNT_WIDTH-1:0] fall_prev_q, fall_prev_d;
  logic [COUNT_WIDTH-1:0] period_q, period_d;
  logic [COUNT_WIDTH-1:0] high_q, high_d;
  logic [31:0]            cap_wide;
  logic [COUNT_WIDTH-1:0] cap_cnt;
  logic                   accept;
  logic                   no_wrap;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign cap_wide   = 32'(in_i.capture_count);
  assign cap_cnt    = cap_wide[COUNT_WIDTH-1:0];
  assign no_wrap    = (rise_prev_q > rise_new_q) && (fall_prev_q > fall_new_q);

  always_comb begin
    rise_new_d  = rise_new_q;
    rise_prev_d = rise_prev_q;
    fall_new_d  = fall_new_q;
    fall_prev_d = fall_prev_q;
    period_d    = period_q;
    high_d      = high_q;
    push_o      = 1'b0;
    if (accept) begin
      unique case (in_i.action)
        ACT_RISE: begin
          rise_prev_d = rise_new_q;
          rise_new_d  = cap_cnt;
        end
        ACT_FALL: begin
          fall_prev_d = fall_new_q;
          fall_new_d  = cap_cnt;
        end
        ACT_MEASURE: begin
          push_o = 1'b1;
          // keep the old values when the timer wrapped between edges
          if (no_wrap) begin
            period_d = rise_prev_q - rise_new_q;
            if (rise_new_q > fall_new_q) begin
              high_d = rise_new_q - fall_new_q;
            end else begin
              high_d = rise_prev_q - fall_new_q;
            end
          end
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  assign push_period_o = period_d;
  assign push_high_o   = high_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_new_q  <= '0;
      rise_prev_q <= '0;
      fall_new_q  <= '0;
      fall_prev_q <= '0;
      period_q    <= '0;
      high_q      <= '0;
    end else begin
      rise_new_q  <= rise_new_d;
      rise_prev_q <= rise_prev_d;
      fall_new_q  <= fall_new_d;
      fall_prev_q <= fall_prev_d;
      period_q    <= period_d;
      high_q      <= high_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pdc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_queue: short first-in first-out queue of measure entries
// Decouples the capture front from the divider back; head shows directly.
// ----------------------------------------------------------------------------
module pdc_queue #(
  parameter int unsigned COUNT_WIDTH = pdc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [COUNT_WIDTH-1:0] push_period_i,
  input  logic [COUNT_WIDTH-1:0] push_high_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output logic [COUNT_WIDTH-1:0] head_period_o,
  output logic [COUNT_WIDTH-1:0] head_high_o
);
  import pdc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DATA_W = 2 * COUNT_WIDTH;

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (fill_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  assign {head_period_o, head_high_o} = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end else begin
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= {push_period_i, push_high_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // the front must never push into a full queue: that entry would be lost
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("measure entry pushed into full queue");

  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (fill_q == $past(fill_q) + 1'b1))
    else $error("queue fill count lost a push");

endmodule
`default_nettype wire

[hw/rtl/pdc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_back: frequency and duty divider with result register
// Pops one measure entry, runs two restoring dividers side by side (clock
// over period, high time times 100 over period, skipped for a zero period), and holds the result.
// ----------------------------------------------------------------------------
module pdc_back #(
  parameter int unsigned COUNT_WIDTH = pdc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  logic [COUNT_WIDTH-1:0]        q_period_i,
  input  logic [COUNT_WIDTH-1:0]        q_high_i,
  output logic                          q_pop_o,
  input  logic [pdc_pkg::CLOCK_W-1:0]   clock_hz_i,
  pdc_out_if.source                     out_o
);
  import pdc_pkg::*;

  localparam int unsigned PROD_W = COUNT_WIDTH + SCALE_W;
  localparam int unsigned DW     = (PROD_W > CLOCK_W) ? PROD_W : CLOCK_W;
  localparam int unsigned CNT_W  = $clog2(DW + 1);

  pdc_state_e             state_q, state_d;
  logic [DW-1:0]          fq_q, fq_d;
  logic [COUNT_WIDTH-1:0] fr_q, fr_d;
  logic [DW-1:0]          dq_q, dq_d;
  logic [COUNT_WIDTH-1:0] dr_q, dr_d;
  logic [COUNT_WIDTH-1:0] div_q, div_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   nop_q, nop_d;
  logic [COUNT_WIDTH:0]   f_sh, d_sh, div_ext;
  logic [COUNT_WIDTH:0]   f_sub, d_sub;
  logic [PROD_W-1:0]      high_scaled;

  assign div_ext     = {1'b0, div_q};
  assign f_sh        = {fr_q, fq_q[DW-1]};
  assign d_sh        = {dr_q, dq_q[DW-1]};
  assign f_sub       = f_sh - div_ext;
  assign d_sub       = d_sh - div_ext;
  assign high_scaled = PROD_W'(q_high_i) * PROD_W'(DUTY_SCALE);

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    fq_d    = fq_q;
    fr_d    = fr_q;
    dq_d    = dq_q;
    dr_d    = dr_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    nop_d   = nop_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          fr_d  = '0;
          dr_d  = '0;
          div_d = q_period_i;
          cnt_d = CNT_W'(DW);
          if (q_period_i == '0) begin
            // no period known: give zeros straight away
            fq_d    = '0;
            dq_d    = '0;
            nop_d   = 1'b1;
            state_d = ST_OUT;
          end else begin
            fq_d    = DW'(clock_hz_i);
            dq_d    = DW'(high_scaled);
            nop_d   = 1'b0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle in each lane
        if (f_sh >= div_ext) begin
          fr_d = f_sub[COUNT_WIDTH-1:0];
          fq_d = {fq_q[DW-2:0], 1'b1};
        end else begin
          fr_d = f_sh[COUNT_WIDTH-1:0];
          fq_d = {fq_q[DW-2:0], 1'b0};
        end
        if (d_sh >= div_ext) begin
          dr_d = d_sub[COUNT_WIDTH-1:0];
          dq_d = {dq_q[DW-2:0], 1'b1};
        end else begin
          dr_d = d_sh[COUNT_WIDTH-1:0];
          dq_d = {dq_q[DW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_o.valid        = (state_q == ST_OUT);
  assign out_o.frequency_hz = fq_q[FREQ_W-1:0];
  assign out_o.duty_percent = (dq_q > DW'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : dq_q[DUTY_W-1:0];
  assign out_o.no_period    = nop_q;

  always_ff @(posedge clk_i) begin
    fq_q  <= fq_d;
    fr_q  <= fr_d;
    dq_q  <= dq_d;
    dr_q  <= dr_d;
    div_q <= div_d;
    nop_q <= nop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == ST_DIV || state_q == ST_OUT))
    else $error("popped entry did not start the divider");

  a_nop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.no_period) |->
      (out_o.frequency_hz == '0 && out_o.duty_percent == '0))
    else $error("result without period carries nonzero values");

endmodule
`default_nettype wire

[hw/rtl/pwm_period_duty_capture_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_period_duty_capture_top: PWM frequency and duty measurement
// Input transactions on in_i carry a rising capture, a falling capture or a
// measure request with a down-counter value. A capture transaction updates
// the edge registers and gives no result. A measure transaction goes into a
// two-entry queue; the divider back end pops it, makes DW quotient bits
// (DW = max(27, COUNT_WIDTH + 7)) and then shows one result transaction on
// out_o: frequency_hz, duty_percent and no_period. The divider makes one
// quotient bit per cycle and pops no new measure until the result is taken;
// a zero period skips the divider. in_i stays ready while the queue has
// room, so captures and up to two measures are taken while a result waits
// for out_o.ready; a stalled result holds its values. cfg_we_i writes the
// timer clock rate in hertz from cfg_wdata_i; write it only while no measure
// is in flight.
// Reset clears all counts, the kept period and high time and the queue,
// returns the divider to idle, and sets the clock rate to 32000000.
// ----------------------------------------------------------------------------
module pwm_period_duty_capture_top #(
  parameter int unsigned COUNT_WIDTH = pdc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pdc_in_if.sink                       in_i,
  pdc_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [pdc_pkg::CLOCK_W-1:0]  cfg_wdata_i
);
  import pdc_pkg::*;

  logic [CLOCK_W-1:0]     clock_hz_q;
  logic                   push;
  logic [COUNT_WIDTH-1:0] push_period;
  logic [COUNT_WIDTH-1:0] push_high;
  logic                   full;
  logic                   pop;
  logic                   head_valid;
  logic [COUNT_WIDTH-1:0] head_period;
  logic [COUNT_WIDTH-1:0] head_high;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= CLOCK_HZ_RESET;
    end else if (cfg_we_i) begin
      clock_hz_q <= cfg_wdata_i;
    end
  end

  pdc_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .push_o        (push),
    .push_period_o (push_period),
    .push_high_o   (push_high),
    .full_i        (full)
  );

  pdc_queue #(.COUNT_WIDTH(COUNT_WIDTH)) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_period_i (push_period),
    .push_high_i   (push_high),
    .full_o        (full),
    .pop_i         (pop),
    .valid_o       (head_valid),
    .head_period_o (head_period),
    .head_high_o   (head_high)
  );

  pdc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (head_valid),
    .q_period_i (head_period),
    .q_high_i   (head_high),
    .q_pop_o    (pop),
    .clock_hz_i (clock_hz_q),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the PWM period and duty capture block
// Drives capture and measure transactions with random gaps, stalls the result
// side at random and for two long stretches, and rewrites the timer clock rate
// between phases. A local model of the edge registers and the kept period
// and high time predicts every measure result for a field-by-field check.
// ----------------------------------------------------------------------------
module tb_top;
  import pdc_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned PIPE_SETTLE  = 32;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef struct {
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    logic              no_period;
  } pwm_meas_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CLOCK_W-1:0]  cfg_wdata_i;

  pdc_in_if  in_ch ();
  pdc_out_if out_ch ();

  pwm_period_duty_capture_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Local copy of the measurement state
  logic [CAPTURE_W-1:0] rise_new, rise_prev, fall_new, fall_prev;
  logic [CAPTURE_W-1:0] period_held, high_held;
  logic [CLOCK_W-1:0]   clock_rate;

  pwm_meas_t   meas_expect_q[$];
  int unsigned err_count;
  int unsigned n_captures, n_measures, n_results, n_ignored, n_clock_writes;
  int unsigned cycle_count;
  int unsigned rx_hold_cycles;
  bit          tx_no_idle, rx_no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d results pending",
               cycle_count, meas_expect_q.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic void predict_item(input logic [ACTION_W-1:0] act,
                                       input logic [CAPTURE_W-1:0] cnt);
    pwm_meas_t   m;
    logic [31:0] duty;
    case (act)
      ACT_RISE: begin
        rise_prev = rise_new;
        rise_new  = cnt;
        n_captures++;
      end
      ACT_FALL: begin
        fall_prev = fall_new;
        fall_new  = cnt;
        n_captures++;
      end
      ACT_MEASURE: begin
        // update only when neither edge pair wrapped
        if (rise_prev > rise_new && fall_prev > fall_new) begin
          period_held = rise_prev - rise_new;
          high_held   = (rise_new > fall_new) ? rise_new - fall_new : rise_prev - fall_new;
        end
        if (period_held == '0) begin
          m.freq      = '0;
          m.duty      = '0;
          m.no_period = 1'b1;
        end else begin
          m.freq = clock_rate / period_held;
          duty   = (32'(high_held) * 32'd100) / 32'(period_held);
          if (duty > DUTY_MAX) duty = DUTY_MAX;
          m.duty      = duty[DUTY_W-1:0];
          m.no_period = 1'b0;
        end
        meas_expect_q.push_back(m);
        n_measures++;
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic void report_field(input string field, input longint unsigned exp_v,
                                       input longint unsigned act_v);
    err_count++;
    if (err_count <= 10)
      $display("tb_top: result %0d %s mismatch: expected %0d, got %0d",
               n_results, field, exp_v, act_v);
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    pwm_meas_t m;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (meas_expect_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("tb_top: unexpected result freq=%0d duty=%0d no_period=%0b",
                   out_ch.frequency_hz, out_ch.duty_percent, out_ch.no_period);
      end else begin
        m = meas_expect_q.pop_front();
        if (out_ch.frequency_hz !== m.freq)
          report_field("frequency_hz", m.freq, out_ch.frequency_hz);
        if (out_ch.duty_percent !== m.duty)
          report_field("duty_percent", m.duty, out_ch.duty_percent);
        if (out_ch.no_period !== m.no_period)
          report_field("no_period", m.no_period, out_ch.no_period);
      end
      n_results++;
    end
  end

  // Result-side ready: random stalls, plus a long hold when a test asks
  initial begin : rx_ready_driver
    int unsigned stall;
    out_ch.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      stall = rx_no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid && rx_hold_cycles == 0);
    end
  end

  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [CAPTURE_W-1:0] cnt);
    int unsigned gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.capture_count <= cnt;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(act, cnt);
  endtask

  // Drop valid, wait for every pending result, then let the divider settle
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (meas_expect_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_clock_rate(input logic [CLOCK_W-1:0] rate);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    clock_rate = rate;
    n_clock_writes++;
  endtask

  // One edge set from a down counter followed by one or two measures
  task automatic send_pulse_train();
    logic [CAPTURE_W-1:0] rp, rn, fp, fn;
    int unsigned          per;
    rp  = CAPTURE_W'($urandom_range(1, 65535));
    per = ($urandom_range(0, 3) == 0) ? $urandom_range(1, rp)
                                      : $urandom_range(1, (rp < 256) ? rp : 256);
    rn  = CAPTURE_W'(rp - per);
    fp  = CAPTURE_W'($urandom_range(1, 65535));
    fn  = CAPTURE_W'($urandom_range(0, fp - 1));
    if ($urandom_range(0, 1) == 0) begin
      send_item(ACT_RISE, rp);
      send_item(ACT_RISE, rn);
      send_item(ACT_FALL, fp);
      send_item(ACT_FALL, fn);
    end else begin
      send_item(ACT_FALL, fp);
      send_item(ACT_RISE, rp);
      send_item(ACT_FALL, fn);
      send_item(ACT_RISE, rn);
    end
    repeat ($urandom_range(1, 2)) send_item(ACT_MEASURE, 16'($urandom));
  endtask

  task automatic test_directed_cases();
    // no period known yet
    send_item(ACT_MEASURE, 16'hFFFF);
    send_item(ACT_SPARE, 16'hFFFF);
    // rising count above falling count
    send_item(ACT_RISE, 16'd60000);
    send_item(ACT_RISE, 16'd50000);
    send_item(ACT_FALL, 16'hFFFF);
    send_item(ACT_FALL, 16'd47000);
    send_item(ACT_MEASURE, 16'h0000);
    // widest period, high time from the previous rising count
    send_item(ACT_RISE, 16'hFFFF);
    send_item(ACT_RISE, 16'h0000);
    send_item(ACT_FALL, 16'hFFFF);
    send_item(ACT_FALL, 16'h0000);
    send_item(ACT_MEASURE, 16'h5A5A);
    // high time past the period: duty saturates
    send_item(ACT_RISE, 16'd100);
    send_item(ACT_RISE, 16'd90);
    send_item(ACT_FALL, 16'd50);
    send_item(ACT_FALL, 16'd0);
    send_item(ACT_MEASURE, 16'hA5A5);
    // wrapped rising pair: keep the last period
    send_item(ACT_RISE, 16'd10);
    send_item(ACT_RISE, 16'd20);
    send_item(ACT_MEASURE, 16'h0001);
    // period of one count
    send_item(ACT_RISE, 16'd5);
    send_item(ACT_RISE, 16'd4);
    send_item(ACT_FALL, 16'd3);
    send_item(ACT_FALL, 16'd2);
    send_item(ACT_MEASURE, 16'h8000);
    quiesce();
  endtask

  task automatic test_clock_rates();
    logic [CLOCK_W-1:0] rates[5];
    rates = '{27'd0, 27'd1, 27'd100000000, 27'h7FFFFFF, 27'd12345};
    // kept period is still one count here
    foreach (rates[i]) begin
      write_clock_rate(rates[i]);
      send_item(ACT_MEASURE, 16'($urandom));
    end
    send_item(ACT_RISE, 16'hFFFF);
    send_item(ACT_RISE, 16'h0000);
    send_item(ACT_FALL, 16'd1);
    send_item(ACT_FALL, 16'd0);
    foreach (rates[i]) begin
      write_clock_rate(rates[i]);
      send_item(ACT_MEASURE, 16'($urandom));
    end
    write_clock_rate(CLOCK_HZ_RESET);
  endtask

  task automatic test_random_traffic();
    int unsigned start, phase;
    start = n_captures + n_measures;
    phase = 0;
    while (n_captures + n_measures - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0)
        send_item(ACTION_W'($urandom_range(0, 3)), 16'($urandom));
      else
        send_pulse_train();
      if (n_captures + n_measures - start >= (phase + 1) * (RANDOM_ITEMS / 4)) begin
        phase++;
        case (phase)
          1:       write_clock_rate(CLOCK_W'($urandom_range(1, 1000)));
          2:       write_clock_rate(CLOCK_W'($urandom_range(1, 100000000)));
          default: write_clock_rate(CLOCK_W'($urandom));
        endcase
        // one phase runs with no idling on either side
        tx_no_idle = (phase == 2);
        rx_no_idle = (phase == 2);
      end
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    quiesce();
  endtask

  task automatic test_result_backpressure();
    rx_hold_cycles = LONG_HOLD;
    tx_no_idle     = 1'b1;
    repeat (8) send_pulse_train();
    tx_no_idle = 1'b0;
    quiesce();
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.action        <= ACT_RISE;
    in_ch.capture_count <= '0;
    {rise_new, rise_prev, fall_new, fall_prev} = '0;
    {period_held, high_held}                   = '0;
    clock_rate     = CLOCK_HZ_RESET;
    err_count      = 0;
    n_captures     = 0;
    n_measures     = 0;
    n_results      = 0;
    n_ignored      = 0;
    n_clock_writes = 0;
    rx_hold_cycles = 0;
    tx_no_idle     = 1'b0;
    rx_no_idle     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_clock_rates();
    test_result_backpressure();
    test_random_traffic();
    test_result_backpressure();

    quiesce();
    err_count += meas_expect_q.size();
    $display("tb_top: %0d captures, %0d measures, %0d results checked, %0d ignored items",
             n_captures, n_measures, n_results, n_ignored);
    $display("tb_top: %0d clock rate writes, %0d mismatches, %0d cycles",
             n_clock_writes, err_count, cycle_count);
    if (err_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_if.sv
hw/rtl/pdc_front.sv
hw/rtl/pdc_queue.sv
hw/rtl/pdc_back.sv
hw/rtl/pwm_period_duty_capture_top.sv
tb/sv/tb_top.sv
